FILE: design/assert_macros.svh
// assertion macros used by the port checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain implication, sampled on the rising clock, off during reset
`define CESD_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("cesd assertion failed");

// implication whose consequent is checked in the next cycle
`define CESD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("cesd assertion failed");

`endif

FILE: design/cesd_pkg.sv
// package: types, codes and character tables of the escape sequence decoder
`default_nettype none

package cesd_pkg;

  localparam int unsigned MODE_W = 3;
  localparam logic [MODE_W-1:0] MODE_NORMAL  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ESCAPE  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_HEX     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_OCTAL   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_STOPPED = 3'd4;

  localparam logic [7:0] CHAR_NUL       = 8'h00;
  localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHAR_HEX_INTRO = 8'h78;
  localparam logic [7:0] CHAR_ZERO      = 8'h30;
  localparam logic [7:0] CHAR_SEVEN     = 8'h37;
  localparam logic [7:0] CHAR_NINE      = 8'h39;
  localparam logic [7:0] CHAR_LOWER_A   = 8'h61;
  localparam logic [7:0] CHAR_LOWER_F   = 8'h66;
  localparam logic [7:0] CHAR_UPPER_A   = 8'h41;
  localparam logic [7:0] CHAR_UPPER_F   = 8'h46;
  localparam logic [3:0] HEX_LETTER_BASE = 4'd10;

  localparam int unsigned QUEUE_DEPTH = 3;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last_of_run;
    logic       literal_done;
    logic       hex_out_of_range;
    logic       octal_out_of_range;
  } result_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] value;
  } char_map_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] value;
  } digit_t;

  function automatic char_map_t simple_escape(input logic [7:0] c);
    char_map_t r;
    r.hit = 1'b1;
    case (c)
      8'h61:   r.value = 8'd7;
      8'h62:   r.value = 8'd8;
      8'h74:   r.value = 8'd9;
      8'h6E:   r.value = 8'd10;
      8'h76:   r.value = 8'd11;
      8'h66:   r.value = 8'd12;
      8'h72:   r.value = 8'd13;
      8'h27:   r.value = 8'd39;
      8'h22:   r.value = 8'd34;
      8'h5C:   r.value = 8'd92;
      default: begin
        r.hit   = 1'b0;
        r.value = 8'd0;
      end
    endcase
    return r;
  endfunction

  function automatic digit_t hex_digit(input logic [7:0] c);
    digit_t r;
    r.hit   = 1'b1;
    r.value = 4'd0;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      r.value = c[3:0];
    end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
      r.value = 4'(c - CHAR_LOWER_A) + HEX_LETTER_BASE;
    end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
      r.value = 4'(c - CHAR_UPPER_A) + HEX_LETTER_BASE;
    end else begin
      r.hit = 1'b0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: design/c_escape_sequence_decoder.sv
// top level: c string literal escape sequence decoder
// results are registered in a three-entry queue; its head register drives the outputs
// throughput: one request per cycle while each gives at most one result and the
//   output is not stalled; a request with two results takes two queue entries
// reset: asynchronous, clears decode mode, accumulator, sticky flags and result queue
`default_nettype none

module c_escape_sequence_decoder (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] lit_byte_i,
  input  wire logic       end_of_literal_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic            byte_valid_o,
  output logic            last_of_run_o,
  output logic            literal_done_o,
  output logic            hex_out_of_range_o,
  output logic            octal_out_of_range_o
);

  localparam int unsigned QD = cesd_pkg::QUEUE_DEPTH;

  logic [cesd_pkg::MODE_W-1:0] mode_q, mode_d;
  logic [7:0] accum_q, accum_d;
  logic       hex_q, hex_d;
  logic       oct_q, oct_d;

  cesd_pkg::result_t slot_q [QD];
  cesd_pkg::result_t slot_d [QD];
  cesd_pkg::result_t shifted [QD];
  cesd_pkg::result_t res0, res1;
  logic [1:0] count_q, count_d;
  logic [1:0] rem;
  logic [1:0] push_n;
  logic [1:0] k;

  logic accept, pop;
  logic first_v, plain_go, second_v, second_done;
  logic [7:0] first_b;
  cesd_pkg::char_map_t esc;
  cesd_pkg::digit_t    hdig;
  logic odig;

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (count_q >= 2'd2);
  assign out_valid_o = (count_q != 2'd0);
  assign pop         = out_valid_o && !out_stall_i;

  assign esc  = cesd_pkg::simple_escape(lit_byte_i);
  assign hdig = cesd_pkg::hex_digit(lit_byte_i);
  assign odig = (lit_byte_i >= cesd_pkg::CHAR_ZERO) && (lit_byte_i <= cesd_pkg::CHAR_SEVEN);

  // decode step
  always_comb begin
    mode_d      = mode_q;
    accum_d     = accum_q;
    hex_d       = hex_q;
    oct_d       = oct_q;
    first_v     = 1'b0;
    first_b     = 8'd0;
    plain_go    = 1'b0;
    second_v    = 1'b0;
    second_done = 1'b0;
    if (end_of_literal_i) begin
      if (mode_q == cesd_pkg::MODE_ESCAPE) begin
        first_v = 1'b1;
        first_b = cesd_pkg::CHAR_BACKSLASH;
      end else if (mode_q == cesd_pkg::MODE_HEX || mode_q == cesd_pkg::MODE_OCTAL) begin
        first_v = 1'b1;
        first_b = accum_q;
      end
      second_v    = 1'b1;
      second_done = 1'b1;
      mode_d      = cesd_pkg::MODE_NORMAL;
      accum_d     = 8'd0;
      hex_d       = 1'b0;
      oct_d       = 1'b0;
    end else begin
      case (mode_q)
        cesd_pkg::MODE_NORMAL: begin
          plain_go = 1'b1;
        end
        cesd_pkg::MODE_ESCAPE: begin
          if (esc.hit) begin
            first_v = 1'b1;
            first_b = esc.value;
            mode_d  = cesd_pkg::MODE_NORMAL;
          end else if (lit_byte_i == cesd_pkg::CHAR_HEX_INTRO) begin
            accum_d = 8'd0;
            mode_d  = cesd_pkg::MODE_HEX;
          end else if (lit_byte_i == cesd_pkg::CHAR_ZERO) begin
            accum_d = 8'd0;
            mode_d  = cesd_pkg::MODE_OCTAL;
          end else begin
            first_v  = 1'b1;
            first_b  = cesd_pkg::CHAR_BACKSLASH;
            mode_d   = cesd_pkg::MODE_NORMAL;
            plain_go = 1'b1;
          end
        end
        cesd_pkg::MODE_HEX: begin
          if (hdig.hit) begin
            if (accum_q[7:4] != 4'd0) begin
              hex_d = 1'b1;
            end
            accum_d = {accum_q[3:0], hdig.value};
          end else begin
            first_v  = 1'b1;
            first_b  = accum_q;
            mode_d   = cesd_pkg::MODE_NORMAL;
            plain_go = 1'b1;
          end
        end
        cesd_pkg::MODE_OCTAL: begin
          if (odig) begin
            if (accum_q[7:5] != 3'd0) begin
              oct_d = 1'b1;
            end
            accum_d = {accum_q[4:0], lit_byte_i[2:0]};
          end else begin
            first_v  = 1'b1;
            first_b  = accum_q;
            mode_d   = cesd_pkg::MODE_NORMAL;
            plain_go = 1'b1;
          end
        end
        default: begin
        end
      endcase
      if (plain_go) begin
        if (lit_byte_i == cesd_pkg::CHAR_NUL) begin
          mode_d = cesd_pkg::MODE_STOPPED;
        end else if (lit_byte_i == cesd_pkg::CHAR_BACKSLASH) begin
          mode_d = cesd_pkg::MODE_ESCAPE;
        end else begin
          second_v = 1'b1;
        end
      end
    end
  end

  // pack the results of this request
  always_comb begin
    cesd_pkg::result_t fr, sr;
    fr.out_byte           = first_b;
    fr.byte_valid         = 1'b1;
    fr.last_of_run        = !second_v;
    fr.literal_done       = 1'b0;
    fr.hex_out_of_range   = hex_q;
    fr.octal_out_of_range = oct_q;
    sr.out_byte           = second_done ? 8'd0 : lit_byte_i;
    sr.byte_valid         = !second_done;
    sr.last_of_run        = 1'b1;
    sr.literal_done       = second_done;
    sr.hex_out_of_range   = hex_q;
    sr.octal_out_of_range = oct_q;
    res0   = first_v ? fr : sr;
    res1   = sr;
    push_n = accept ? ({1'b0, first_v} + {1'b0, second_v}) : 2'd0;
  end

  // result queue, head is the output register
  always_comb begin
    for (int i = 0; i < QD - 1; i++) begin
      shifted[i] = slot_q[i+1];
    end
    shifted[QD-1] = slot_q[QD-1];
    rem     = count_q - {1'b0, pop};
    count_d = rem + push_n;
    k       = 2'd0;
    for (int i = 0; i < QD; i++) begin
      if (2'(i) < rem) begin
        slot_d[i] = pop ? shifted[i] : slot_q[i];
      end else begin
        k = 2'(i) - rem;
        if (k == 2'd0) begin
          slot_d[i] = res0;
        end else begin
          slot_d[i] = res1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= cesd_pkg::MODE_NORMAL;
      accum_q <= 8'd0;
      hex_q   <= 1'b0;
      oct_q   <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (accept) begin
        mode_q  <= mode_d;
        accum_q <= accum_d;
        hex_q   <= hex_d;
        oct_q   <= oct_d;
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QD; i++) begin
      slot_q[i] <= slot_d[i];
    end
  end

  assign out_byte_o           = slot_q[0].out_byte;
  assign byte_valid_o         = slot_q[0].byte_valid;
  assign last_of_run_o        = slot_q[0].last_of_run;
  assign literal_done_o       = slot_q[0].literal_done;
  assign hex_out_of_range_o   = slot_q[0].hex_out_of_range;
  assign octal_out_of_range_o = slot_q[0].octal_out_of_range;

endmodule

`default_nettype wire

FILE: design/cesd_checker.sv
// port checker of the escape sequence decoder and its bind
`default_nettype none

`include "assert_macros.svh"

module cesd_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic       end_of_literal_i,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [7:0] out_byte_o,
  input wire logic       byte_valid_o,
  input wire logic       last_of_run_o,
  input wire logic       literal_done_o,
  input wire logic       hex_out_of_range_o,
  input wire logic       octal_out_of_range_o
);

  logic        out_held;
  logic        end_taken;
  logic [12:0] out_fields;

  assign out_held   = out_valid_o && out_stall_i;
  assign end_taken  = in_valid_i && !in_stall_o && end_of_literal_i;
  assign out_fields = {out_byte_o, byte_valid_o, last_of_run_o, literal_done_o,
                       hex_out_of_range_o, octal_out_of_range_o};

  `CESD_ASSERT_NEXT(a_out_valid_held, clk_i, rst_ni, out_held, out_valid_o)
  `CESD_ASSERT_NEXT(a_out_byte_held, clk_i, rst_ni, out_held, $stable(out_fields))
  `CESD_ASSERT_IMPL(a_done_is_last_status, clk_i, rst_ni, out_valid_o && literal_done_o,
                    last_of_run_o && !byte_valid_o)
  `CESD_ASSERT_IMPL(a_status_only_on_done, clk_i, rst_ni, out_valid_o && !byte_valid_o,
                    literal_done_o && (out_byte_o == 8'd0))
  `CESD_ASSERT_NEXT(a_end_gives_result, clk_i, rst_ni, end_taken, out_valid_o)

endmodule

bind c_escape_sequence_decoder cesd_checker u_cesd_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .in_valid_i           (in_valid_i),
  .in_stall_o           (in_stall_o),
  .end_of_literal_i     (end_of_literal_i),
  .out_valid_o          (out_valid_o),
  .out_stall_i          (out_stall_i),
  .out_byte_o           (out_byte_o),
  .byte_valid_o         (byte_valid_o),
  .last_of_run_o        (last_of_run_o),
  .literal_done_o       (literal_done_o),
  .hex_out_of_range_o   (hex_out_of_range_o),
  .octal_out_of_range_o (octal_out_of_range_o)
);

`default_nettype wire

FILE: test/c_escape_sequence_decoder_tb.sv
// testbench for the escape sequence decoder: directed and random literals against a model
`default_nettype none

module c_escape_sequence_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RANDOM_REQUESTS = 420;
  localparam int unsigned CALM_TAIL = 60;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned MAX_REPORTS = 40;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] lit_byte_i = 8'h00;
  logic       end_of_literal_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] out_byte_o;
  logic       byte_valid_o;
  logic       last_of_run_o;
  logic       literal_done_o;
  logic       hex_out_of_range_o;
  logic       octal_out_of_range_o;

  c_escape_sequence_decoder i_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .lit_byte_i          (lit_byte_i),
    .end_of_literal_i    (end_of_literal_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .out_byte_o          (out_byte_o),
    .byte_valid_o        (byte_valid_o),
    .last_of_run_o       (last_of_run_o),
    .literal_done_o      (literal_done_o),
    .hex_out_of_range_o  (hex_out_of_range_o),
    .octal_out_of_range_o(octal_out_of_range_o)
  );

  always #5 clk_i = ~clk_i;

  logic [7:0] simple_chars [10] = '{"a", "b", "t", "n", "v", "f", "r", "'", "\"",
                                    cesd_pkg::CHAR_BACKSLASH};

  // decoder model state
  logic [cesd_pkg::MODE_W-1:0] mode_st = cesd_pkg::MODE_NORMAL;
  logic [7:0]                  accum_st = 8'h00;
  logic                        hex_sticky = 1'b0;
  logic                        oct_sticky = 1'b0;
  cesd_pkg::result_t           run_res [2];
  int                          run_n;

  cesd_pkg::result_t decoded_q [$];

  int errors = 0;
  int reports = 0;
  int requests_sent = 0;
  int literals_closed = 0;
  int results_checked = 0;
  int cycle_count = 0;
  bit calm_tail = 1'b0;

  function automatic void emit(input logic is_byte, input logic [7:0] b, input logic done);
    cesd_pkg::result_t r;
    r.out_byte           = is_byte ? b : 8'h00;
    r.byte_valid         = is_byte;
    r.last_of_run        = 1'b0;
    r.literal_done       = done;
    r.hex_out_of_range   = hex_sticky;
    r.octal_out_of_range = oct_sticky;
    if (run_n < 2) begin
      run_res[run_n] = r;
      run_n++;
    end
  endfunction

  function automatic void take_plain(input logic [7:0] c);
    if (c == cesd_pkg::CHAR_NUL) begin
      mode_st = cesd_pkg::MODE_STOPPED;
    end else if (c == cesd_pkg::CHAR_BACKSLASH) begin
      mode_st = cesd_pkg::MODE_ESCAPE;
    end else begin
      emit(1'b1, c, 1'b0);
    end
  endfunction

  function automatic void take_escaped(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    mode_st = cesd_pkg::MODE_NORMAL;
    case (c)
      "a": v = 8'd7;
      "b": v = 8'd8;
      "t": v = 8'd9;
      "n": v = 8'd10;
      "v": v = 8'd11;
      "f": v = 8'd12;
      "r": v = 8'd13;
      "'": v = 8'd39;
      "\"": v = 8'd34;
      cesd_pkg::CHAR_BACKSLASH: v = 8'd92;
      cesd_pkg::CHAR_HEX_INTRO: begin
        accum_st = 8'h00;
        mode_st  = cesd_pkg::MODE_HEX;
        return;
      end
      cesd_pkg::CHAR_ZERO: begin
        accum_st = 8'h00;
        mode_st  = cesd_pkg::MODE_OCTAL;
        return;
      end
      default: begin
        // unknown escape: backslash goes out, the byte is taken again as plain text
        emit(1'b1, cesd_pkg::CHAR_BACKSLASH, 1'b0);
        take_plain(c);
        return;
      end
    endcase
    emit(1'b1, v, 1'b0);
  endfunction

  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= cesd_pkg::CHAR_ZERO && c <= cesd_pkg::CHAR_NINE)
      return int'(c - cesd_pkg::CHAR_ZERO);
    if (c >= cesd_pkg::CHAR_LOWER_A && c <= cesd_pkg::CHAR_LOWER_F)
      return int'(c - cesd_pkg::CHAR_LOWER_A) + 10;
    if (c >= cesd_pkg::CHAR_UPPER_A && c <= cesd_pkg::CHAR_UPPER_F)
      return int'(c - cesd_pkg::CHAR_UPPER_A) + 10;
    return -1;
  endfunction

  task automatic decode_request(input logic [7:0] c, input logic fin);
    int d;
    run_n = 0;
    if (fin) begin
      if (mode_st == cesd_pkg::MODE_ESCAPE) begin
        emit(1'b1, cesd_pkg::CHAR_BACKSLASH, 1'b0);
      end else if (mode_st == cesd_pkg::MODE_HEX || mode_st == cesd_pkg::MODE_OCTAL) begin
        emit(1'b1, accum_st, 1'b0);
      end
      emit(1'b0, 8'h00, 1'b1);
      mode_st    = cesd_pkg::MODE_NORMAL;
      accum_st   = 8'h00;
      hex_sticky = 1'b0;
      oct_sticky = 1'b0;
    end else begin
      case (mode_st)
        cesd_pkg::MODE_NORMAL: take_plain(c);
        cesd_pkg::MODE_ESCAPE: take_escaped(c);
        cesd_pkg::MODE_HEX: begin
          d = hex_nibble(c);
          if (d >= 0) begin
            if (accum_st[7:4] != 4'h0) hex_sticky = 1'b1;
            accum_st = {accum_st[3:0], 4'(d)};
          end else begin
            mode_st = cesd_pkg::MODE_NORMAL;
            emit(1'b1, accum_st, 1'b0);
            take_plain(c);
          end
        end
        cesd_pkg::MODE_OCTAL: begin
          if (c >= cesd_pkg::CHAR_ZERO && c <= cesd_pkg::CHAR_SEVEN) begin
            if (accum_st[7:5] != 3'h0) oct_sticky = 1'b1;
            accum_st = {accum_st[4:0], c[2:0]};
          end else begin
            mode_st = cesd_pkg::MODE_NORMAL;
            emit(1'b1, accum_st, 1'b0);
            take_plain(c);
          end
        end
        default: ;
      endcase
    end
    if (run_n > 0) run_res[run_n-1].last_of_run = 1'b1;
    for (int i = 0; i < run_n; i++) decoded_q.push_back(run_res[i]);
  endtask

  task automatic send_request(input logic [7:0] b, input logic fin);
    if (!calm_tail && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    lit_byte_i       <= b;
    end_of_literal_i <= fin;
    @(negedge clk_i);
    while (in_stall_o) @(negedge clk_i);
    @(posedge clk_i);
    decode_request(b, fin);
    requests_sent++;
    if (fin) literals_closed++;
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      errors++;
      if (reports < MAX_REPORTS) begin
        reports++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    end
  endtask

  // receiver stalls
  initial begin
    forever begin
      @(posedge clk_i);
      if (!calm_tail && $urandom_range(0, 4) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
    end
  end

  // result checker, sampled on the falling edge before the accepting rising edge
  always @(negedge clk_i) begin : result_check
    cesd_pkg::result_t got;
    cesd_pkg::result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {out_byte_o, byte_valid_o, last_of_run_o, literal_done_o,
             hex_out_of_range_o, octal_out_of_range_o};
      results_checked++;
      if (decoded_q.size() == 0) begin
        errors++;
        if (reports < MAX_REPORTS) begin
          reports++;
          $display("%0t: unexpected result, expected none, actual %0h", $time, got);
        end
      end else begin
        want = decoded_q.pop_front();
        check_field("out_byte", want.out_byte, got.out_byte);
        check_field("byte_valid", 8'(want.byte_valid), 8'(got.byte_valid));
        check_field("last_of_run", 8'(want.last_of_run), 8'(got.last_of_run));
        check_field("literal_done", 8'(want.literal_done), 8'(got.literal_done));
        check_field("hex_out_of_range", 8'(want.hex_out_of_range),
                    8'(got.hex_out_of_range));
        check_field("octal_out_of_range", 8'(want.octal_out_of_range),
                    8'(got.octal_out_of_range));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic test_simple_escapes;
    send_request(cesd_pkg::CHAR_BACKSLASH, 1'b0);
    send_request("a", 1'b0);
    send_request(cesd_pkg::CHAR_BACKSLASH, 1'b0);
    send_request(cesd_pkg::CHAR_BACKSLASH, 1'b0);
    send_request(cesd_pkg::CHAR_BACKSLASH, 1'b0);
    send_request("\"", 1'b0);
    send_request(8'hFF, 1'b0);
    send_request(8'h01, 1'b0);
  endtask

  task automatic test_hex_overflow;
    send_request(cesd_pkg::CHAR_BACKSLASH, 1'b0);
    send_request(cesd_pkg::CHAR_HEX_INTRO, 1'b0);
    send_request("F", 1'b0);
    send_request("f", 1'b0);
    send_request("9", 1'b0);
    send_request("g", 1'b0);
    send_request(8'h00, 1'b1);
  endtask

  task automatic test_octal_overflow;
    send_request(cesd_pkg::CHAR_BACKSLASH, 1'b0);
    send_request(cesd_pkg::CHAR_ZERO, 1'b0);
    send_request(cesd_pkg::CHAR_SEVEN, 1'b0);
    send_request(cesd_pkg::CHAR_SEVEN, 1'b0);
    send_request(cesd_pkg::CHAR_SEVEN, 1'b0);
    send_request(8'hFF, 1'b1);
  endtask

  task automatic test_unknown_escape_and_nul;
    send_request(cesd_pkg::CHAR_BACKSLASH, 1'b0);
    send_request("q", 1'b0);
    send_request(cesd_pkg::CHAR_BACKSLASH, 1'b0);
    send_request(cesd_pkg::CHAR_NUL, 1'b0);
    send_request("z", 1'b0);
    send_request(8'h00, 1'b1);
  endtask

  task automatic test_pending_backslash;
    send_request(cesd_pkg::CHAR_BACKSLASH, 1'b0);
    send_request(8'h5A, 1'b1);
  endtask

  task automatic test_random_literals(input int target);
    logic [7:0] text [$];
    logic [7:0] b;
    int seg;
    int digits;
    int v;
    bit hit;
    while (requests_sent < target) begin
      text.delete();
      repeat ($urandom_range(1, 8)) begin
        seg = $urandom_range(0, 29);
        if (seg < 8) begin
          b = (seg < 6) ? 8'($urandom_range(8'h20, 8'h7E)) : 8'($urandom_range(1, 255));
          if (b == cesd_pkg::CHAR_BACKSLASH) b = "A";
          text.push_back(b);
        end else if (seg < 12) begin
          text.push_back(cesd_pkg::CHAR_BACKSLASH);
          text.push_back(simple_chars[$urandom_range(0, 9)]);
        end else if (seg < 17) begin
          text.push_back(cesd_pkg::CHAR_BACKSLASH);
          text.push_back(cesd_pkg::CHAR_HEX_INTRO);
          digits = $urandom_range(0, 4);
          repeat (digits) begin
            v = $urandom_range(0, 15);
            if (v < 10) b = cesd_pkg::CHAR_ZERO + 8'(v);
            else if ($urandom_range(0, 1) == 1) b = cesd_pkg::CHAR_LOWER_A + 8'(v - 10);
            else b = cesd_pkg::CHAR_UPPER_A + 8'(v - 10);
            text.push_back(b);
          end
        end else if (seg < 22) begin
          text.push_back(cesd_pkg::CHAR_BACKSLASH);
          text.push_back(cesd_pkg::CHAR_ZERO);
          digits = $urandom_range(0, 4);
          repeat (digits) text.push_back(cesd_pkg::CHAR_ZERO + 8'($urandom_range(0, 7)));
        end else if (seg < 25) begin
          // backslash before a character with no escape meaning
          forever begin
            b = 8'($urandom);
            hit = (b == cesd_pkg::CHAR_HEX_INTRO) || (b == cesd_pkg::CHAR_ZERO);
            foreach (simple_chars[i]) if (b == simple_chars[i]) hit = 1'b1;
            if (!hit) break;
          end
          text.push_back(cesd_pkg::CHAR_BACKSLASH);
          text.push_back(b);
        end else if (seg < 29) begin
          text.push_back(8'($urandom));
        end else begin
          text.push_back(cesd_pkg::CHAR_NUL);
          text.push_back(8'($urandom));
        end
      end
      if ($urandom_range(0, 7) == 0) text.push_back(cesd_pkg::CHAR_BACKSLASH);
      foreach (text[i]) begin
        if (requests_sent >= target - int'(CALM_TAIL)) calm_tail = 1'b1;
        send_request(text[i], 1'b0);
      end
      send_request(8'($urandom), 1'b1);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_simple_escapes();
    test_hex_overflow();
    test_octal_overflow();
    test_unknown_escape_and_nul();
    test_pending_backslash();
    test_random_literals(requests_sent + RANDOM_REQUESTS);

    in_valid_i <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (decoded_q.size() != 0) errors++;

    $display("sent %0d requests across %0d literals, checked %0d decoded results",
             requests_sent, literals_closed, results_checked);
    $display("covered simple, hex, octal and unknown escapes, overflow, NUL stop and flushes");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
